/* sv/template_code_tokenizer_unit_defines.svh */
// Assertion macros used by the tokenizer checker.
`ifndef TEMPLATE_CODE_TOKENIZER_UNIT_DEFINES_SVH
`define TEMPLATE_CODE_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define TCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, off during reset
`define TCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

// next-cycle implication, always on
`define TCT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

/* sv/tct_pkg.sv */
// Shared types and constants of the template code tokenizer.
package tct_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MAX_RES           = 4;
    localparam int IDX_W             = $clog2(MAX_RES);
    localparam int NRES_W            = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH        = 8;

    // token kinds
    localparam logic [2:0] KIND_NONCODE  = 3'd0;
    localparam logic [2:0] KIND_WORD     = 3'd1;
    localparam logic [2:0] KIND_OPERATOR = 3'd2;
    localparam logic [2:0] KIND_STRING   = 3'd3;
    localparam logic [2:0] KIND_NUMBER   = 3'd4;

    // event kinds
    localparam logic EV_CONTENT = 1'b0;
    localparam logic EV_END     = 1'b1;

    // lexer modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_NONCODE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPRUN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WORD     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NUMBER   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STRING   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LINECMT  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BLOCKCMT = 3'd7;

    // characters with a role in the marks
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    typedef struct packed {
        logic        event_kind;
        logic [7:0]  char_out;
        logic [2:0]  token_kind;
        logic [15:0] start_row;
        logic [15:0] start_col;
        logic        last;
    } t_res;

endpackage

/* sv/tct_if.sv */
// Handshake channels of the tokenizer: source bytes in, token events out.
interface tct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface tct_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [7:0]  char_out;
    logic [2:0]  token_kind;
    logic [15:0] start_row;
    logic [15:0] start_col;
    logic        last;

    modport source (output valid, output event_kind, output char_out, output token_kind,
                    output start_row, output start_col, output last, input ready);
    modport sink (input valid, input event_kind, input char_out, input token_kind,
                  input start_row, input start_col, input last, output ready);
endinterface

/* sv/tct_step.sv */
// Lexer state and the combinational per-byte tokenizing step.
module tct_step #(
    parameter int POSITION_BITS = tct_pkg::POSITION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  logic [7:0]                           i_byte,
    input  logic                                 i_eoi,
    output tct_pkg::t_res [tct_pkg::MAX_RES-1:0] o_res,
    output logic [tct_pkg::NRES_W-1:0]           o_nres
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] PMAX = '1;

    typedef struct packed {
        logic [P-1:0] row;
        logic [P-1:0] col;
    } t_pos;

    logic [tct_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [7:0]                 r_hb, n_hb;
    logic                       r_hv, n_hv;
    t_pos                       r_pos, n_pos;
    logic [P-1:0]               r_trow, n_trow;
    logic [P-1:0]               r_tcol, n_tcol;
    logic                       r_topen, n_topen;

    tct_pkg::t_res [tct_pkg::MAX_RES-1:0] res;
    logic [tct_pkg::NRES_W-1:0]           k;
    logic                                 consumed;
    logic                                 go_idle;
    logic [7:0]                           c;
    logic [7:0]                           h;
    logic [8:0]                           esc_r;
    logic [2:0]                           wkind;

    function automatic t_pos adv(input t_pos p, input logic [7:0] ch);
        t_pos q;
        q = p;
        if (ch == tct_pkg::CH_LF) begin
            if (p.row != PMAX) q.row = p.row + 1'b1;
            q.col = '0;
        end else if (p.col != PMAX) begin
            q.col = p.col + 1'b1;
        end
        return q;
    endfunction

    function automatic logic [15:0] clip(input logic [P-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic tct_pkg::t_res mk(input logic ev, input logic [7:0] ch,
                                         input logic [2:0] kind, input logic [P-1:0] trow,
                                         input logic [P-1:0] tcol);
        tct_pkg::t_res e;
        e.event_kind = ev;
        e.char_out   = ch;
        e.token_kind = kind;
        e.start_row  = clip(trow);
        e.start_col  = clip(tcol);
        e.last       = 1'b0;
        return e;
    endfunction

    function automatic logic is_single_op(input logic [7:0] ch);
        return ch == "(" || ch == ")" || ch == "[" || ch == "]" || ch == "{" ||
               ch == "}" || ch == "," || ch == ";";
    endfunction

    function automatic logic is_run_op(input logic [7:0] ch);
        return ch == "<" || ch == ">" || ch == "=" || ch == ":" || ch == "+" ||
               ch == "-" || ch == "*" || ch == "/" || ch == "|" || ch == "&" ||
               ch == "!";
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch == tct_pkg::CH_SP || (ch >= tct_pkg::CH_TAB && ch <= tct_pkg::CH_CR);
    endfunction

    function automatic logic ends_word(input logic [7:0] ch);
        return is_single_op(ch) || is_run_op(ch) || ch == tct_pkg::CH_SP ||
               ch == tct_pkg::CH_PCT || ch == tct_pkg::CH_QUEST || ch == tct_pkg::CH_NUL ||
               ch == tct_pkg::CH_TAB || ch == tct_pkg::CH_CR || ch == tct_pkg::CH_LF ||
               ch == tct_pkg::CH_BSL;
    endfunction

    // {known, translated byte}
    function automatic logic [8:0] esc(input logic [7:0] ch);
        logic [8:0] r;
        unique case (ch)
            tct_pkg::CH_DQ:  r = {1'b1, tct_pkg::CH_DQ};
            tct_pkg::CH_BSL: r = {1'b1, tct_pkg::CH_BSL};
            "b":             r = {1'b1, 8'd8};
            "f":             r = {1'b1, 8'd12};
            "n":             r = {1'b1, 8'd10};
            "r":             r = {1'b1, 8'd13};
            "t":             r = {1'b1, 8'd9};
            "v":             r = {1'b1, 8'd11};
            default:         r = 9'd0;
        endcase
        return r;
    endfunction

    always_comb begin
        n_mode   = r_mode;
        n_hb     = r_hb;
        n_hv     = r_hv;
        n_pos    = r_pos;
        n_trow   = r_trow;
        n_tcol   = r_tcol;
        n_topen  = r_topen;
        res      = '0;
        k        = '0;
        consumed = 1'b0;
        go_idle  = 1'b0;
        c        = i_byte;
        h        = r_hb;
        esc_r    = esc(i_byte);
        wkind    = (r_mode == tct_pkg::MODE_WORD) ? tct_pkg::KIND_WORD : tct_pkg::KIND_NUMBER;

        // settle the held byte against the new one
        if (r_hv) begin
            n_hv = 1'b0;
            n_hb = '0;
            case (r_mode)
                tct_pkg::MODE_NONCODE: begin
                    if (c == tct_pkg::CH_QUEST) begin
                        if (n_topen) begin
                            res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                                tct_pkg::KIND_NONCODE, n_trow, n_tcol);
                            k = k + 1'b1;
                            n_topen = 1'b0;
                        end
                        n_pos    = adv(adv(n_pos, h), c);
                        n_mode   = tct_pkg::MODE_CODE;
                        consumed = 1'b1;
                    end else begin
                        if (!n_topen) begin
                            n_topen = 1'b1;
                            n_trow  = n_pos.row;
                            n_tcol  = n_pos.col;
                        end
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, h,
                            tct_pkg::KIND_NONCODE, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos = adv(n_pos, h);
                    end
                end
                tct_pkg::MODE_CODE: begin
                    if (h == tct_pkg::CH_QUEST) begin
                        if (c == tct_pkg::CH_GT) begin
                            n_pos    = adv(adv(n_pos, h), c);
                            n_mode   = tct_pkg::MODE_NONCODE;
                            consumed = 1'b1;
                        end else begin
                            n_pos = adv(n_pos, h);
                        end
                    end else if (c == tct_pkg::CH_SLASH || c == tct_pkg::CH_STAR) begin
                        n_pos    = adv(adv(n_pos, h), c);
                        n_mode   = (c == tct_pkg::CH_SLASH) ? tct_pkg::MODE_LINECMT
                                                            : tct_pkg::MODE_BLOCKCMT;
                        consumed = 1'b1;
                    end else begin
                        n_topen = 1'b1;
                        n_trow  = n_pos.row;
                        n_tcol  = n_pos.col;
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, h,
                            tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos  = adv(n_pos, h);
                        n_mode = tct_pkg::MODE_OPRUN;
                    end
                end
                tct_pkg::MODE_LINECMT: begin
                    n_pos = adv(n_pos, h);
                    if (c == tct_pkg::CH_GT) begin
                        n_pos    = adv(n_pos, c);
                        n_mode   = tct_pkg::MODE_NONCODE;
                        consumed = 1'b1;
                    end
                end
                tct_pkg::MODE_BLOCKCMT: begin
                    n_pos = adv(n_pos, h);
                    if (c == tct_pkg::CH_SLASH) begin
                        n_pos    = adv(n_pos, c);
                        n_mode   = tct_pkg::MODE_CODE;
                        consumed = 1'b1;
                    end
                end
                tct_pkg::MODE_STRING: begin
                    if (esc_r[8]) begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, esc_r[7:0],
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                    end else begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, h,
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                    end
                    n_pos    = adv(adv(n_pos, h), c);
                    consumed = 1'b1;
                end
                default: ;
            endcase
        end

        // the new byte in the current mode
        if (!consumed) begin
            case (n_mode)
                tct_pkg::MODE_NONCODE: begin
                    if (c == tct_pkg::CH_LT) begin
                        n_hb = c;
                        n_hv = 1'b1;
                    end else begin
                        if (!n_topen) begin
                            n_topen = 1'b1;
                            n_trow  = n_pos.row;
                            n_tcol  = n_pos.col;
                        end
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                            tct_pkg::KIND_NONCODE, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos = adv(n_pos, c);
                    end
                end
                tct_pkg::MODE_OPRUN: begin
                    if (is_run_op(c)) begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                            tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos = adv(n_pos, c);
                    end else begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                            tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_topen = 1'b0;
                        n_mode  = tct_pkg::MODE_CODE;
                        go_idle = 1'b1;
                    end
                end
                tct_pkg::MODE_WORD, tct_pkg::MODE_NUMBER: begin
                    if (ends_word(c)) begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0, wkind,
                            n_trow, n_tcol);
                        k = k + 1'b1;
                        n_topen = 1'b0;
                        n_mode  = tct_pkg::MODE_CODE;
                        go_idle = 1'b1;
                    end else begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c, wkind,
                            n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos = adv(n_pos, c);
                    end
                end
                tct_pkg::MODE_STRING: begin
                    if (c == tct_pkg::CH_DQ) begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_topen = 1'b0;
                        n_pos   = adv(n_pos, c);
                        n_mode  = tct_pkg::MODE_CODE;
                    end else if (c == tct_pkg::CH_BSL) begin
                        n_hb = c;
                        n_hv = 1'b1;
                    end else begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                        n_pos = adv(n_pos, c);
                    end
                end
                tct_pkg::MODE_LINECMT: begin
                    if (c == tct_pkg::CH_LF) begin
                        n_pos  = adv(n_pos, c);
                        n_mode = tct_pkg::MODE_CODE;
                    end else if (c == tct_pkg::CH_QUEST) begin
                        n_hb = c;
                        n_hv = 1'b1;
                    end else begin
                        n_pos = adv(n_pos, c);
                    end
                end
                tct_pkg::MODE_BLOCKCMT: begin
                    if (c == tct_pkg::CH_STAR) begin
                        n_hb = c;
                        n_hv = 1'b1;
                    end else begin
                        n_pos = adv(n_pos, c);
                    end
                end
                default: begin
                    n_mode  = tct_pkg::MODE_CODE;
                    go_idle = 1'b1;
                end
            endcase

            // between tokens in code
            if (go_idle) begin
                priority if (is_space(c)) begin
                    n_pos = adv(n_pos, c);
                end else if (c == tct_pkg::CH_QUEST || c == tct_pkg::CH_SLASH) begin
                    n_hb = c;
                    n_hv = 1'b1;
                end else if (c == tct_pkg::CH_DQ) begin
                    n_topen = 1'b1;
                    n_trow  = n_pos.row;
                    n_tcol  = n_pos.col;
                    n_pos   = adv(n_pos, c);
                    n_mode  = tct_pkg::MODE_STRING;
                end else if (is_single_op(c)) begin
                    n_trow = n_pos.row;
                    n_tcol = n_pos.col;
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                        tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                    k = k + 1'b1;
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                        tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                    k = k + 1'b1;
                    n_topen = 1'b0;
                    n_pos   = adv(n_pos, c);
                end else if (is_run_op(c)) begin
                    n_topen = 1'b1;
                    n_trow  = n_pos.row;
                    n_tcol  = n_pos.col;
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                        tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                    k = k + 1'b1;
                    n_pos  = adv(n_pos, c);
                    n_mode = tct_pkg::MODE_OPRUN;
                end else if (c == tct_pkg::CH_PCT || c == tct_pkg::CH_BSL ||
                             c == tct_pkg::CH_NUL) begin
                    n_pos = adv(n_pos, c);
                end else begin
                    n_topen = 1'b1;
                    n_trow  = n_pos.row;
                    n_tcol  = n_pos.col;
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, c,
                        (c >= "0" && c <= "9") ? tct_pkg::KIND_NUMBER : tct_pkg::KIND_WORD,
                        n_trow, n_tcol);
                    k = k + 1'b1;
                    n_pos  = adv(n_pos, c);
                    n_mode = (c >= "0" && c <= "9") ? tct_pkg::MODE_NUMBER
                                                    : tct_pkg::MODE_WORD;
                end
            end
        end

        // end of source: flush the held byte and any open token, then reset the lexer state
        if (i_eoi) begin
            if (n_hv) begin
                case (n_mode)
                    tct_pkg::MODE_NONCODE: begin
                        if (!n_topen) begin
                            n_topen = 1'b1;
                            n_trow  = n_pos.row;
                            n_tcol  = n_pos.col;
                        end
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, n_hb,
                            tct_pkg::KIND_NONCODE, n_trow, n_tcol);
                        k = k + 1'b1;
                    end
                    tct_pkg::MODE_CODE: begin
                        if (n_hb != tct_pkg::CH_QUEST) begin
                            n_trow = n_pos.row;
                            n_tcol = n_pos.col;
                            res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, n_hb,
                                tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                            k = k + 1'b1;
                            n_mode = tct_pkg::MODE_OPRUN;
                        end
                    end
                    tct_pkg::MODE_STRING: begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_CONTENT, n_hb,
                            tct_pkg::KIND_STRING, n_trow, n_tcol);
                        k = k + 1'b1;
                    end
                    default: ;
                endcase
            end
            case (n_mode)
                tct_pkg::MODE_NONCODE: begin
                    if (n_topen) begin
                        res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                            tct_pkg::KIND_NONCODE, n_trow, n_tcol);
                        k = k + 1'b1;
                    end
                end
                tct_pkg::MODE_OPRUN: begin
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                        tct_pkg::KIND_OPERATOR, n_trow, n_tcol);
                    k = k + 1'b1;
                end
                tct_pkg::MODE_WORD: begin
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                        tct_pkg::KIND_WORD, n_trow, n_tcol);
                    k = k + 1'b1;
                end
                tct_pkg::MODE_NUMBER: begin
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                        tct_pkg::KIND_NUMBER, n_trow, n_tcol);
                    k = k + 1'b1;
                end
                tct_pkg::MODE_STRING: begin
                    res[k[tct_pkg::IDX_W-1:0]] = mk(tct_pkg::EV_END, '0,
                        tct_pkg::KIND_STRING, n_trow, n_tcol);
                    k = k + 1'b1;
                end
                default: ;
            endcase
            n_mode  = tct_pkg::MODE_NONCODE;
            n_hb    = '0;
            n_hv    = 1'b0;
            n_pos   = '0;
            n_trow  = '0;
            n_tcol  = '0;
            n_topen = 1'b0;
        end

        if (k != '0) res[k[tct_pkg::IDX_W-1:0] - 1'b1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tct_pkg::MODE_NONCODE;
            r_hb    <= '0;
            r_hv    <= 1'b0;
            r_pos   <= '0;
            r_trow  <= '0;
            r_tcol  <= '0;
            r_topen <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_hb    <= n_hb;
            r_hv    <= n_hv;
            r_pos   <= n_pos;
            r_trow  <= n_trow;
            r_tcol  <= n_tcol;
            r_topen <= n_topen;
        end
    end

    assign o_res  = res;
    assign o_nres = k;

endmodule

/* sv/template_code_tokenizer_unit.sv */
// Top level of the template code tokenizer: input register, lexer step, result queue.
//
//  channel | modport      | handshake         | word
//  i_src   | tct_in_if    | valid/ready, sink | byte_in, end_of_input
//  o_res   | tct_out_if   | valid/ready, src  | event_kind, char_out, token_kind,
//          |              |                   | start_row, start_col, last
//
// One source byte per cycle while each byte yields at most one event and the output
// is not stalled; a byte's events leave one at a time by the single output port of the
// eight-entry result queue. A byte leaves the input register once the queue has room
// for four events; its events are then written into the queue and leave from its head.
// Synchronous reset clears lexer state, input register and queue.
module template_code_tokenizer_unit #(
    parameter int POSITION_BITS = tct_pkg::POSITION_BITS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tct_in_if.sink    i_src,
    tct_out_if.source o_res
);

    localparam int DEPTH = tct_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic                                 r_in_valid;
    logic [7:0]                           r_in_byte;
    logic                                 r_in_eoi;
    tct_pkg::t_res                        r_fifo [DEPTH];
    logic [PTR_W-1:0]                     r_wr_ptr;
    logic [PTR_W-1:0]                     r_rd_ptr;
    logic [CNT_W-1:0]                     r_cnt;
    logic                                 w_fire;
    logic                                 w_pop;
    logic                                 w_room;
    logic                                 w_in_ready;
    tct_pkg::t_res [tct_pkg::MAX_RES-1:0] w_res;
    logic [tct_pkg::NRES_W-1:0]           w_nres;
    tct_pkg::t_res                        w_head;

    assign w_pop  = o_res.valid && o_res.ready;
    assign w_room = (SUM_W'(r_cnt) + SUM_W'(tct_pkg::MAX_RES) - SUM_W'(w_pop))
                    <= SUM_W'(DEPTH);
    assign w_fire     = r_in_valid && w_room;
    assign w_in_ready = !r_in_valid || w_fire;
    assign i_src.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_src.valid) begin
            r_in_byte <= i_src.byte_in;
            r_in_eoi  <= i_src.end_of_input;
        end
    end

    tct_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_res   (w_res),
        .o_nres  (w_nres)
    );

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_fire) r_wr_ptr <= r_wr_ptr + PTR_W'(w_nres);
            if (w_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= r_cnt + (w_fire ? CNT_W'(w_nres) : '0) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tct_pkg::MAX_RES; i++) begin
            if (w_fire && tct_pkg::NRES_W'(i) < w_nres) begin
                r_fifo[r_wr_ptr + PTR_W'(i)] <= w_res[i];
            end
        end
    end

    assign w_head           = r_fifo[r_rd_ptr];
    assign o_res.valid      = (r_cnt != '0);
    assign o_res.event_kind = w_head.event_kind;
    assign o_res.char_out   = w_head.char_out;
    assign o_res.token_kind = w_head.token_kind;
    assign o_res.start_row  = w_head.start_row;
    assign o_res.start_col  = w_head.start_col;
    assign o_res.last       = w_head.last;

endmodule

/* sv/tct_checker.sv */
// Port-level checks on the tokenizer output, bound to the top level.
`include "template_code_tokenizer_unit_defines.svh"

module tct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_event_kind,
    input logic [7:0]  i_char_out,
    input logic [2:0]  i_token_kind,
    input logic [15:0] i_start_row,
    input logic [15:0] i_start_col,
    input logic        i_last
);

    // queue empties on reset
    `TCT_ASSERT_NXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

    // stalled word holds
    `TCT_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_event_kind, i_char_out, i_token_kind, i_start_row, i_start_col, i_last}))

    // end events carry no byte
    `TCT_ASSERT_IMP(a_end_no_char, i_clk, i_rst_n, i_out_valid && i_event_kind, i_char_out == 8'd0)

    // after a content byte the next word belongs to the same token
    `TCT_ASSERT_NXT(a_same_token, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_event_kind, !i_out_valid || ($stable(i_token_kind) && $stable(i_start_row) && $stable(i_start_col)))

endmodule

bind template_code_tokenizer_unit tct_checker u_tct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_event_kind (o_res.event_kind),
    .i_char_out   (o_res.char_out),
    .i_token_kind (o_res.token_kind),
    .i_start_row  (o_res.start_row),
    .i_start_col  (o_res.start_col),
    .i_last       (o_res.last)
);
